// File: rtl/core/fde_pkg.sv
`default_nettype none

package fde_pkg;

  // default panel size
  localparam int unsigned PANEL_W_DEF = 128;
  localparam int unsigned PANEL_H_DEF = 160;

  // field and working widths
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned COORD_W = 9;
  localparam int unsigned RAD_W   = 8;
  localparam int unsigned COL_W   = 16;
  localparam int unsigned DIM_W   = 10;
  localparam int unsigned CW      = 11;
  localparam int unsigned SQ_W    = 16;

  // register index
  localparam logic REG_ORIENT = 1'b0;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_POINT   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_HSPAN   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_VSPAN   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_OUTLINE = 4'd4;
  localparam logic [KIND_W-1:0] KIND_BOX     = 4'd5;
  localparam logic [KIND_W-1:0] KIND_DISC    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_RING    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_LINE    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_READ    = 4'd9;

  // decoded operation class
  typedef enum logic [3:0] {
    OP_CLEAR, OP_POINT, OP_HSPAN, OP_VSPAN, OP_OUTLINE,
    OP_BOX, OP_DISC, OP_RING, OP_LINE, OP_READ, OP_NONE
  } op_e;

  // one queued command
  typedef struct packed {
    op_e                op;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [RAD_W-1:0]   radius;
    logic [COL_W-1:0]   colour;
  } cmd_t;

  // clamp a signed coordinate to 0 .. lim-1
  function automatic logic signed [CW-1:0] fit(input logic signed [CW-1:0] v,
                                               input logic [DIM_W-1:0] lim);
    logic signed [CW-1:0] top;
    top = $signed({1'b0, lim - 10'd1});
    if (v < 11'sd0) begin
      fit = '0;
    end else if (v > top) begin
      fit = top;
    end else begin
      fit = v;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/fde_front.sv
`default_nettype none

module fde_front
  import fde_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,
  input  wire logic [3:0]  s_tuser,
  output logic             q_vld_o,
  output cmd_t             q_cmd_o,
  input  wire logic        q_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_in;
  logic       push, pop;

  // decode the incoming item
  always_comb begin
    cmd_in.kind   = s_tuser;
    cmd_in.xs     = s_tdata[8:0];
    cmd_in.ys     = s_tdata[17:9];
    cmd_in.xe     = s_tdata[26:18];
    cmd_in.ye     = s_tdata[35:27];
    cmd_in.radius = s_tdata[43:36];
    cmd_in.colour = s_tdata[59:44];
    unique case (s_tuser)
      KIND_CLEAR:   cmd_in.op = OP_CLEAR;
      KIND_POINT:   cmd_in.op = OP_POINT;
      KIND_HSPAN:   cmd_in.op = OP_HSPAN;
      KIND_VSPAN:   cmd_in.op = OP_VSPAN;
      KIND_OUTLINE: cmd_in.op = OP_OUTLINE;
      KIND_BOX:     cmd_in.op = OP_BOX;
      KIND_DISC:    cmd_in.op = OP_DISC;
      KIND_RING:    cmd_in.op = OP_RING;
      KIND_LINE:    cmd_in.op = OP_LINE;
      KIND_READ:    cmd_in.op = OP_READ;
      default:      cmd_in.op = OP_NONE;
    endcase
  end

  assign s_tready = (cnt_q != 2'd2);
  assign push     = s_tvalid & s_tready;
  assign pop      = q_pop_i & q_vld_o;
  assign q_vld_o  = (cnt_q != 2'd0);
  assign q_cmd_o  = fifo_q[rd_ptr_q];

  // two-entry queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fde_isqrt.sv
`default_nettype none

module fde_isqrt
  import fde_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SQ_W-1:0] op_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [RAD_W-1:0]     root_o
);

  logic             busy_q, done_q;
  logic [2:0]       cnt_q;
  logic [SQ_W-1:0]  op_q;
  logic [8:0]       rem_q;
  logic [RAD_W-1:0] root_q;
  logic [10:0]      rem_sh;
  logic [9:0]       trial;
  logic             fits;

  // one result bit per cycle
  assign rem_sh = {rem_q, op_q[SQ_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= {1'b0, trial});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      op_q   <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q <= {op_q[SQ_W-3:0], 2'b00};
      if (fits) begin
        rem_q  <= 9'(rem_sh - {1'b0, trial});
        root_q <= {root_q[RAD_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[8:0];
        root_q <= {root_q[RAD_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// File: rtl/core/fde_back.sv
`default_nettype none

module fde_back
  import fde_pkg::*;
#(
  parameter int unsigned PANEL_W = PANEL_W_DEF,
  parameter int unsigned PANEL_H = PANEL_H_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        swap_i,
  input  wire logic        q_vld_i,
  input  wire cmd_t        q_cmd_i,
  output logic             q_pop_o,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic [3:0]       m_tuser
);

  localparam int unsigned DEPTH = PANEL_W * PANEL_H;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [DIM_W-1:0] PW = DIM_W'(PANEL_W);
  localparam logic [DIM_W-1:0] PH = DIM_W'(PANEL_H);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PLAN  = 7'b0000010,
    ST_SPAN  = 7'b0000100,
    ST_LINE  = 7'b0001000,
    ST_ROOT  = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_DONE  = 7'b1000000
  } st_e;

  st_e st_q, st_d, after_q, after_d;
  cmd_t cmd_q, cmd_d;
  logic [2:0] seg_q, seg_d;
  logic signed [CW-1:0] row_q, row_d, row_end_q, row_end_d;
  logic [8:0] h_q, h_d;
  logic [SQ_W-1:0] sq_q, sq_d;
  logic [RAD_W-1:0] l_q, l_d, p_q, p_d;
  logic rs_q, rs_d, dr_q, dr_d;

  // span walker
  logic wk_vert_q, wk_vert_d;
  logic signed [CW-1:0] wk_fix_q, wk_fix_d, wk_cur_q, wk_cur_d, wk_end_q, wk_end_d;

  // line stepper
  logic ln_ylong_q, ln_ylong_d, ln_neg_q, ln_neg_d, ln_sneg_q, ln_sneg_d;
  logic signed [CW-1:0] ln_i_q, ln_i_d, ln_l_q, ln_l_d;
  logic [DIM_W-1:0] ln_labs_q, ln_labs_d, ln_sabs_q, ln_sabs_d;
  logic [DIM_W-1:0] ln_acc_q, ln_acc_d, ln_off_q, ln_off_d;

  // store pipeline and result
  logic px_vld_q, rd_vld_q, rd_ok_q, rd_ok_d;
  logic [AW-1:0] px_addr_q;
  logic [COL_W-1:0] px_col_q, rdata_q;
  logic [COL_W-1:0] mem_q [DEPTH];
  logic out_vld_q, out_vld_d;
  logic [COL_W-1:0] out_val_q, out_val_d;
  logic [KIND_W-1:0] out_kind_q, out_kind_d;

  // control between sequencer and walker load
  logic ld_go, ld_vert, ld_clamp, rd_req, rt_start;
  logic signed [CW-1:0] ld_fix, ld_a, ld_b;
  logic signed [CW-1:0] lc_fix, lc_a, lc_b;

  logic [DIM_W-1:0] w, h;
  logic signed [CW-1:0] ws, hs;
  logic signed [CW-1:0] xs_s, ys_s, xe_s, ye_s, rr_s, ll_s, pp_s, hh_s;
  logic signed [CW-1:0] em_x, em_y, ad_x, ad_y;
  logic em_vld, in_frame;
  logic rt_busy, rt_done;
  logic [RAD_W-1:0] rt_root;
  logic [2*DIM_W-1:0] addr_full;

  assign w    = swap_i ? PH : PW;
  assign h    = swap_i ? PW : PH;
  assign ws   = $signed({1'b0, w});
  assign hs   = $signed({1'b0, h});
  assign xs_s = $signed({2'b00, cmd_q.xs});
  assign ys_s = $signed({2'b00, cmd_q.ys});
  assign xe_s = $signed({2'b00, cmd_q.xe});
  assign ye_s = $signed({2'b00, cmd_q.ye});
  assign rr_s = $signed({3'b000, cmd_q.radius});
  assign ll_s = $signed({3'b000, l_q});
  assign pp_s = $signed({3'b000, p_q});
  assign hh_s = $signed({2'b00, h_q});

  fde_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_start),
    .op_i    (sq_q),
    .busy_o  (rt_busy),
    .done_o  (rt_done),
    .root_o  (rt_root)
  );

  // clamp (when ld_clamp is set) and order the span being loaded
  always_comb begin
    logic signed [CW-1:0] fa, fb;
    if (ld_clamp) begin
      fa     = fit(ld_a, ld_vert ? h : w);
      fb     = fit(ld_b, ld_vert ? h : w);
      lc_fix = fit(ld_fix, ld_vert ? w : h);
    end else begin
      fa     = ld_a;
      fb     = ld_b;
      lc_fix = ld_fix;
    end
    lc_a = (fa < fb) ? fa : fb;
    lc_b = (fa < fb) ? fb : fa;
  end

  // pixel emitted this cycle
  always_comb begin
    logic signed [CW-1:0] off, lng, sht;
    off    = ln_sneg_q ? -$signed({1'b0, ln_off_q}) : $signed({1'b0, ln_off_q});
    lng    = (ln_ylong_q ? ys_s : xs_s) + ln_i_q;
    sht    = (ln_ylong_q ? xs_s : ys_s) + off;
    em_vld = 1'b0;
    em_x   = wk_vert_q ? wk_fix_q : wk_cur_q;
    em_y   = wk_vert_q ? wk_cur_q : wk_fix_q;
    if (st_q == ST_SPAN) begin
      em_vld = 1'b1;
    end else if (st_q == ST_LINE) begin
      em_vld = 1'b1;
      em_x   = ln_ylong_q ? sht : lng;
      em_y   = ln_ylong_q ? lng : sht;
    end
  end

  assign in_frame  = (em_x >= 11'sd0) && (em_y >= 11'sd0) && (em_x < ws) && (em_y < hs);
  assign ad_x      = rd_req ? xs_s : em_x;
  assign ad_y      = rd_req ? ys_s : em_y;
  assign addr_full = ad_y[DIM_W-1:0] * w + {{DIM_W{1'b0}}, ad_x[DIM_W-1:0]};

  // command sequencer
  always_comb begin
    logic signed [CW-1:0] dx, dy, adx, ady, lsel, ssel, lo, hi;
    logic [DIM_W:0] acc_sum;
    st_d = st_q; after_d = after_q; cmd_d = cmd_q; seg_d = seg_q;
    row_d = row_q; row_end_d = row_end_q; h_d = h_q; sq_d = sq_q;
    l_d = l_q; p_d = p_q; rs_d = rs_q; dr_d = dr_q; rd_ok_d = rd_ok_q;
    wk_vert_d = wk_vert_q; wk_fix_d = wk_fix_q; wk_cur_d = wk_cur_q; wk_end_d = wk_end_q;
    ln_ylong_d = ln_ylong_q; ln_neg_d = ln_neg_q; ln_sneg_d = ln_sneg_q;
    ln_i_d = ln_i_q; ln_l_d = ln_l_q; ln_labs_d = ln_labs_q; ln_sabs_d = ln_sabs_q;
    ln_acc_d = ln_acc_q; ln_off_d = ln_off_q;
    out_vld_d = out_vld_q & ~m_tready; out_val_d = out_val_q; out_kind_d = out_kind_q;
    ld_go = 1'b0; ld_vert = 1'b0; ld_clamp = 1'b1;
    ld_fix = ys_s; ld_a = xs_s; ld_b = xe_s;
    rd_req = 1'b0; rt_start = 1'b0; q_pop_o = 1'b0;
    dx = xe_s - xs_s; dy = ye_s - ys_s;
    adx = (dx < 11'sd0) ? -dx : dx;
    ady = (dy < 11'sd0) ? -dy : dy;
    lsel = (ady > adx) ? dy : dx;
    ssel = (ady > adx) ? dx : dy;
    lo = (q_cmd_i.ys < q_cmd_i.ye) ? $signed({2'b00, q_cmd_i.ys}) : $signed({2'b00, q_cmd_i.ye});
    hi = (q_cmd_i.ys < q_cmd_i.ye) ? $signed({2'b00, q_cmd_i.ye}) : $signed({2'b00, q_cmd_i.ys});
    acc_sum = {1'b0, ln_acc_q} + {1'b0, ln_sabs_q};

    unique case (st_q)
      ST_IDLE: begin
        if (q_vld_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          seg_d   = '0;
          h_d     = 9'd1;
          sq_d    = ({8'd0, q_cmd_i.radius} * {8'd0, q_cmd_i.radius}) - 16'd1;
          p_d     = q_cmd_i.radius;
          rd_ok_d = 1'b0;
          row_d   = fit(lo, h);
          row_end_d = fit(hi, h);
          if (q_cmd_i.op == OP_CLEAR) begin
            cmd_d.xs  = '0;
            cmd_d.xe  = COORD_W'(w - 10'd1);
            row_d     = '0;
            row_end_d = hs - 11'sd1;
          end
          st_d = ST_PLAN;
        end
      end

      ST_PLAN: begin
        st_d    = ST_SPAN;
        after_d = ST_DRAIN;
        case (cmd_q.op)
          OP_CLEAR, OP_BOX: begin
            ld_go  = 1'b1;
            ld_fix = row_q;
            if (row_q != row_end_q) begin
              after_d = ST_PLAN;
              row_d   = row_q + 11'sd1;
            end
          end
          OP_POINT: begin
            ld_go = 1'b1; ld_clamp = 1'b0; ld_b = xs_s;
          end
          OP_HSPAN: ld_go = 1'b1;
          OP_VSPAN: begin
            ld_go = 1'b1; ld_vert = 1'b1; ld_fix = xs_s; ld_a = ys_s; ld_b = ye_s;
          end
          OP_OUTLINE: begin
            ld_go = 1'b1;
            seg_d = seg_q + 3'd1;
            if (seg_q != 3'd3) after_d = ST_PLAN;
            case (seg_q)
              3'd0: begin ld_vert = 1'b1; ld_fix = xs_s; ld_a = ys_s; ld_b = ye_s; end
              3'd1: begin ld_vert = 1'b1; ld_fix = xe_s; ld_a = ys_s; ld_b = ye_s; end
              3'd2: ld_fix = ys_s;
              default: ld_fix = ye_s;
            endcase
          end
          OP_DISC: begin
            ld_go = 1'b1;
            case (seg_q)
              3'd0: begin
                ld_a = xs_s - rr_s; ld_b = xs_s + rr_s;
                seg_d = 3'd1;
                if (cmd_q.radius != '0) after_d = ST_ROOT;
              end
              3'd1: begin
                ld_fix = ys_s + hh_s; ld_a = xs_s - ll_s; ld_b = xs_s + ll_s;
                seg_d = 3'd2; after_d = ST_PLAN;
              end
              default: begin
                ld_fix = ys_s - hh_s; ld_a = xs_s - ll_s; ld_b = xs_s + ll_s;
                seg_d = 3'd1;
                h_d   = h_q + 9'd1;
                sq_d  = sq_q - SQ_W'({h_q, 1'b1});
                if (h_q[RAD_W-1:0] != cmd_q.radius) after_d = ST_ROOT;
              end
            endcase
          end
          OP_RING: begin
            ld_go = 1'b1;
            seg_d = seg_q + 3'd1;
            after_d = ST_PLAN;
            case (seg_q)
              3'd0: begin ld_clamp = 1'b0; ld_a = xs_s - rr_s; ld_b = xs_s - rr_s; end
              3'd1: begin
                ld_clamp = 1'b0; ld_a = xs_s + rr_s; ld_b = xs_s + rr_s;
                after_d = (cmd_q.radius != '0) ? ST_ROOT : ST_DRAIN;
              end
              3'd2: begin ld_fix = ys_s + hh_s; ld_a = xs_s - pp_s; ld_b = xs_s - ll_s; end
              3'd3: begin ld_fix = ys_s + hh_s; ld_a = xs_s + ll_s; ld_b = xs_s + pp_s; end
              3'd4: begin ld_fix = ys_s - hh_s; ld_a = xs_s - pp_s; ld_b = xs_s - ll_s; end
              default: begin
                ld_fix = ys_s - hh_s; ld_a = xs_s + ll_s; ld_b = xs_s + pp_s;
                seg_d = 3'd2;
                p_d   = l_q;
                h_d   = h_q + 9'd1;
                sq_d  = sq_q - SQ_W'({h_q, 1'b1});
                after_d = (h_q[RAD_W-1:0] != cmd_q.radius) ? ST_ROOT : ST_DRAIN;
              end
            endcase
          end
          OP_LINE: begin
            ln_ylong_d = (ady > adx);
            ln_l_d     = lsel;
            ln_neg_d   = (lsel < 11'sd0);
            ln_sneg_d  = (ssel < 11'sd0);
            ln_labs_d  = (lsel < 11'sd0) ? DIM_W'(-lsel) : DIM_W'(lsel);
            ln_sabs_d  = (ssel < 11'sd0) ? DIM_W'(-ssel) : DIM_W'(ssel);
            ln_i_d     = '0;
            ln_acc_d   = '0;
            ln_off_d   = '0;
            st_d = (lsel == 11'sd0) ? ST_DRAIN : ST_LINE;
          end
          OP_READ: begin
            rd_req  = 1'b1;
            rd_ok_d = ({1'b0, cmd_q.xs} < w) && ({1'b0, cmd_q.ys} < h);
            st_d    = ST_DRAIN;
          end
          default: st_d = ST_DRAIN;
        endcase
        if (ld_go) begin
          wk_vert_d = ld_vert;
          wk_fix_d  = lc_fix;
          wk_cur_d  = lc_a;
          wk_end_d  = lc_b;
        end
        dr_d = 1'b0;
      end

      ST_SPAN: begin
        if (wk_cur_q == wk_end_q) st_d = after_q;
        else wk_cur_d = wk_cur_q + 11'sd1;
        dr_d = 1'b0;
      end

      ST_LINE: begin
        ln_i_d = ln_neg_q ? ln_i_q - 11'sd1 : ln_i_q + 11'sd1;
        if (acc_sum >= {1'b0, ln_labs_q}) begin
          ln_acc_d = DIM_W'(acc_sum - {1'b0, ln_labs_q});
          ln_off_d = ln_off_q + 10'd1;
        end else begin
          ln_acc_d = acc_sum[DIM_W-1:0];
        end
        if (ln_i_d == ln_l_q) st_d = ST_DRAIN;
        dr_d = 1'b0;
      end

      ST_ROOT: begin
        if (!rs_q && !rt_busy) begin
          rt_start = 1'b1;
          rs_d     = 1'b1;
        end else if (rt_done) begin
          rs_d = 1'b0;
          l_d  = rt_root;
          st_d = ST_PLAN;
        end
      end

      ST_DRAIN: begin
        dr_d = 1'b1;
        if (dr_q) st_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_vld_q || m_tready) begin
          out_vld_d  = 1'b1;
          out_val_d  = (cmd_q.op == OP_READ && rd_ok_q) ? rdata_q : '0;
          out_kind_d = cmd_q.kind;
          st_d       = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      after_q   <= ST_DRAIN;
      rs_q      <= 1'b0;
      dr_q      <= 1'b0;
      px_vld_q  <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      after_q   <= after_d;
      rs_q      <= rs_d;
      dr_q      <= dr_d;
      px_vld_q  <= em_vld & in_frame;
      rd_vld_q  <= rd_req;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; seg_q <= seg_d; row_q <= row_d; row_end_q <= row_end_d;
    h_q <= h_d; sq_q <= sq_d; l_q <= l_d; p_q <= p_d; rd_ok_q <= rd_ok_d;
    wk_vert_q <= wk_vert_d; wk_fix_q <= wk_fix_d; wk_cur_q <= wk_cur_d;
    wk_end_q <= wk_end_d;
    ln_ylong_q <= ln_ylong_d; ln_neg_q <= ln_neg_d; ln_sneg_q <= ln_sneg_d;
    ln_i_q <= ln_i_d; ln_l_q <= ln_l_d; ln_labs_q <= ln_labs_d;
    ln_sabs_q <= ln_sabs_d; ln_acc_q <= ln_acc_d; ln_off_q <= ln_off_d;
    px_addr_q <= addr_full[AW-1:0];
    px_col_q  <= cmd_q.colour;
    out_val_q <= out_val_d; out_kind_q <= out_kind_d;
  end

  // frame store, one port
  always_ff @(posedge clk_i) begin
    if (px_vld_q) mem_q[px_addr_q] <= px_col_q;
    if (rd_vld_q) rdata_q <= mem_q[px_addr_q];
  end

  assign m_tvalid = out_vld_q;
  assign m_tdata  = out_val_q;
  assign m_tuser  = out_kind_q;

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    px_vld_q |-> (int'(px_addr_q) < DEPTH))
    else $error("pixel address beyond frame store");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(px_vld_q && rd_vld_q))
    else $error("store write and read in the same cycle");

  a_line_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LINE) |-> (ln_acc_q < ln_labs_q))
    else $error("line remainder out of range");

  a_root_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rs_q |-> (st_q == ST_ROOT))
    else $error("square root pending outside root state");

endmodule

`default_nettype wire

// File: rtl/core/framebuffer_draw_engine.sv
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tuser kind; tdata x/y start, x/y end, radius, colour
// m_*       out  m_tvalid/m_tready    tuser done_kind; tdata pixel_value
// apb       in   psel&penable&pwrite  orientation at byte address 0
//
// an item passes through plan, span or line, drain and done, drawing one pixel per cycle,
// and every span it draws is planned in the plan state before it is walked
// clear and box are drawn row by row, each row a span of its own
// disc and ring wait on the square-root unit for the half-width of each row
// reset clears control only; the frame store holds garbage until cleared
// a two-entry queue takes items while the drawing side is busy

`default_nettype none

module framebuffer_draw_engine
  import fde_pkg::*;
#(
  parameter int unsigned PANEL_W = PANEL_W_DEF,
  parameter int unsigned PANEL_H = PANEL_H_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // x_start, y_start, x_end, y_end, radius, colour
  input  wire logic [3:0]  s_tuser,   // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // pixel_value
  output logic [3:0]       m_tuser,   // done_kind
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [1:0] orient_q;
  logic       q_vld, q_pop;
  cmd_t       q_cmd;

  // orientation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= 2'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ORIENT) begin
      orient_q <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ORIENT) ? {30'd0, orient_q} : 32'd0;

  fde_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_vld_o  (q_vld),
    .q_cmd_o  (q_cmd),
    .q_pop_i  (q_pop)
  );

  fde_back #(
    .PANEL_W (PANEL_W),
    .PANEL_H (PANEL_H)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .swap_i   (orient_q[0]),
    .q_vld_i  (q_vld),
    .q_cmd_i  (q_cmd),
    .q_pop_o  (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
